### src/b64enc_pkg.sv
// ----------------------------------------------------------------------------
// Base64 encoder package
// Shared group type, alphabet lookup and character constants for the encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  // One packed group as it travels from the front to the back end.
  typedef struct packed {
    logic [23:0] bits;    // Bytes packed most significant first, zero filled.
    logic [1:0]  nbytes;  // Number of real bytes in the group (1 to 3).
    logic        last;    // Group closes the message.
  } group_t;

  // Position of a character inside its group of four.
  localparam logic [1:0] CharFirst  = 2'd0;
  localparam logic [1:0] CharSecond = 2'd1;
  localparam logic [1:0] CharThird  = 2'd2;
  localparam logic [1:0] CharFourth = 2'd3;

  // Byte counts of a group.
  localparam logic [1:0] OneByte   = 2'd1;
  localparam logic [1:0] TwoBytes  = 2'd2;
  localparam logic [1:0] ThreeByte = 2'd3;

  localparam logic [6:0] PadChar = 7'h3D;  // ASCII '='

  // Standard base64 alphabet, indexed by a six-bit value.
  function automatic logic [6:0] alphabet_char(input logic [5:0] sextet);
    logic [6:0] ch;
    if (sextet < 6'd26) begin
      ch = 7'h41 + {1'b0, sextet};
    end else if (sextet < 6'd52) begin
      ch = 7'h61 + {1'b0, sextet - 6'd26};
    end else if (sextet < 6'd62) begin
      ch = 7'h30 + {1'b0, sextet - 6'd52};
    end else if (sextet == 6'd62) begin
      ch = 7'h2B;  // '+'
    end else begin
      ch = 7'h2F;  // '/'
    end
    return ch;
  endfunction

endpackage

### src/base64_stream_encoder.sv
// The first character of a group reaches the result ports through the group queue,
// the back end's group register and its character register; the other three follow
// one per cycle while pop keeps up. Throughput: one character per cycle, set by the
// back end's character register, as long as the result side pops every cycle.
// Reset (asynchronous, active low) empties the pending group, the group queue
// and the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Streaming base64 encoder
// Byte-at-a-time RFC 4648 encoder with a decoupled front end and back end.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
  parameter int unsigned GroupDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Byte requests.
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  // Character results.
  output logic       empty,
  input  logic       pop,
  output logic [6:0] text_char_o,
  output logic       end_of_text_o
);

  // The front end collects up to two bytes. A request that closes a group
  // (third byte, or any byte flagged final) pushes the packed group into the
  // queue in the same cycle, so the front takes a request whenever the queue
  // has room. Requests that only add to the pending group never touch the
  // queue, but refusing them on a full queue keeps the rule simple.
  logic               accept;
  logic               grp_wr;
  b64enc_pkg::group_t grp_wr_data;
  logic               gq_full;

  // The back end drains the queue one group at a time and writes one character
  // per cycle into its output register while that register is free; the result
  // side sees that register, so the back end stalls while a character waits there.
  logic               gq_empty;
  logic               grp_take;
  b64enc_pkg::group_t grp_rd_data;
  logic               out_valid;

  assign full   = gq_full;
  assign accept = push && !gq_full;
  assign empty  = !out_valid;

  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .grp_valid_o  (grp_wr),
    .grp_o        (grp_wr_data)
  );

  b64enc_gq #(
    .Depth (GroupDepth)
  ) u_gq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (grp_wr),
    .wr_data_i (grp_wr_data),
    .full_o    (gq_full),
    .rd_en_i   (grp_take),
    .rd_data_o (grp_rd_data),
    .empty_o   (gq_empty)
  );

  // A result request is taken when pop meets a valid character in the
  // output register; the back end refills that register in the same edge.
  b64enc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grp_empty_i   (gq_empty),
    .grp_i         (grp_rd_data),
    .grp_take_o    (grp_take),
    .pop_i         (pop),
    .out_valid_o   (out_valid),
    .text_char_o   (text_char_o),
    .end_of_text_o (end_of_text_o)
  );

endmodule

### src/b64enc_front.sv
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Collects bytes into groups of up to three and hands closed groups onward.
// ----------------------------------------------------------------------------
module b64enc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  final_byte_i,
  output logic                  grp_valid_o,
  output b64enc_pkg::group_t    grp_o
);

  logic [15:0] pending_bytes_q, pending_bytes_d;
  logic [1:0]  pending_count_q, pending_count_d;

  // A group closes on the third byte or on the last byte of the message.
  always_comb begin
    pending_bytes_d = pending_bytes_q;
    pending_count_d = pending_count_q;
    grp_valid_o     = 1'b0;
    grp_o.bits      = {data_byte_i, 16'h0000};
    grp_o.nbytes    = b64enc_pkg::OneByte;
    grp_o.last      = final_byte_i;
    unique case (pending_count_q)
      2'd1: begin
        grp_o.bits   = {pending_bytes_q[15:8], data_byte_i, 8'h00};
        grp_o.nbytes = b64enc_pkg::TwoBytes;
        if (final_byte_i) begin
          grp_valid_o = accept_i;
        end else begin
          pending_bytes_d = {pending_bytes_q[15:8], data_byte_i};
        end
      end
      2'd2: begin
        grp_o.bits   = {pending_bytes_q, data_byte_i};
        grp_o.nbytes = b64enc_pkg::ThreeByte;
        grp_valid_o  = accept_i;
      end
      default: begin
        // An empty group; a count of three is never reached and counts as empty.
        if (final_byte_i) begin
          grp_valid_o = accept_i;
        end else begin
          pending_bytes_d = {data_byte_i, 8'h00};
        end
      end
    endcase
    if (accept_i) begin
      if (grp_valid_o) begin
        pending_count_d = 2'd0;
      end else begin
        pending_count_d = (pending_count_q == 2'd1) ? 2'd2 : 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_count_q <= 2'd0;
    end else begin
      pending_count_q <= pending_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pending_bytes_q <= pending_bytes_d;
    end
  end

endmodule

### src/b64enc_gq.sv
// ----------------------------------------------------------------------------
// Base64 encoder group queue
// Small first-in first-out buffer of closed groups between front and back.
// ----------------------------------------------------------------------------
module b64enc_gq #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  b64enc_pkg::group_t    wr_data_i,
  output logic                  full_o,
  input  logic                  rd_en_i,
  output b64enc_pkg::group_t    rd_data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  b64enc_pkg::group_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;

  assign full_o    = (count_q == CntFull);
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en_i && !rd_en_i) begin
        count_q <= count_q + 1'b1;
      end else if (rd_en_i && !wr_en_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### src/b64enc_back.sv
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Turns one group into four characters, one per cycle while the output is free.
// ----------------------------------------------------------------------------
module b64enc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  grp_empty_i,
  input  b64enc_pkg::group_t    grp_i,
  output logic                  grp_take_o,
  input  logic                  pop_i,
  output logic                  out_valid_o,
  output logic [6:0]            text_char_o,
  output logic                  end_of_text_o
);

  b64enc_pkg::group_t grp_q, grp_d;
  logic               busy_q, busy_d;
  logic [1:0]         idx_q, idx_d;
  logic               ovalid_q, ovalid_d;
  logic [6:0]         char_q, char_d;
  logic               eot_q, eot_d;
  logic               out_free;
  logic [5:0]         sextet;
  logic               pad;

  assign out_free = !ovalid_q || pop_i;

  // Six bits from the top down, then padding where the group ran short.
  always_comb begin
    unique case (idx_q)
      b64enc_pkg::CharFirst:  sextet = grp_q.bits[23:18];
      b64enc_pkg::CharSecond: sextet = grp_q.bits[17:12];
      b64enc_pkg::CharThird:  sextet = grp_q.bits[11:6];
      default:                sextet = grp_q.bits[5:0];
    endcase
    pad = ((idx_q == b64enc_pkg::CharThird) && (grp_q.nbytes == b64enc_pkg::OneByte)) ||
          ((idx_q == b64enc_pkg::CharFourth) && (grp_q.nbytes != b64enc_pkg::ThreeByte));
  end

  always_comb begin
    grp_d    = grp_q;
    busy_d   = busy_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    char_d   = char_q;
    eot_d    = eot_q;
    if (out_free) begin
      ovalid_d = busy_q;
      if (busy_q) begin
        char_d = pad ? b64enc_pkg::PadChar : b64enc_pkg::alphabet_char(sextet);
        eot_d  = grp_q.last && (idx_q == b64enc_pkg::CharFourth);
        idx_d  = idx_q + 2'd1;
        if (idx_q == b64enc_pkg::CharFourth) begin
          busy_d = 1'b0;
        end
      end
    end
    // A new group enters as soon as the current one hands out its last character.
    grp_take_o = !grp_empty_i &&
                 (!busy_q || (out_free && (idx_q == b64enc_pkg::CharFourth)));
    if (grp_take_o) begin
      grp_d  = grp_i;
      busy_d = 1'b1;
      idx_d  = b64enc_pkg::CharFirst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= b64enc_pkg::CharFirst;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q  <= grp_d;
    char_q <= char_d;
    eot_q  <= eot_d;
  end

  assign out_valid_o   = ovalid_q;
  assign text_char_o   = char_q;
  assign end_of_text_o = eot_q;

endmodule
